[sv/gdds_pkg.sv]
// gdds_pkg: shared types, constants and calendar functions for the date stepper
// used by gdds_ctrl, gdds_datapath and gregorian_date_day_stepper
`default_nettype none

package gdds_pkg;

    // field widths
    localparam int DAY_W       = 5;
    localparam int MONTH_W     = 4;
    localparam int YEAR_W      = 14;
    localparam int DAY_COUNT_W = 12;

    // low bits of day_count that are honored
    localparam int COUNT_BITS  = 12;
    localparam int CNT_W       = (COUNT_BITS < DAY_COUNT_W) ? COUNT_BITS : DAY_COUNT_W;

    // stream packing
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 2;

    // calendar limits
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
    localparam logic [DAY_W-1:0]   DAY_LAST  = DAY_W'(31);

    // year mod 400 by reciprocal: q = (y * 40) >> 14 is floor(y/400) or one less
    localparam int LEAP_CYCLE  = 400;
    localparam int QUOT_MUL    = 40;
    localparam int DIV_SHIFT   = 14;
    localparam int Q_W         = 6;
    localparam int R_W         = 9;

    // direction codes
    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_BWD = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic calc_q;
        logic calc_r;
        logic check;
        logic step;
        logic set_err;
        logic load_out;
    } gdds_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic done;
        logic at_limit;
        logic out_free;
    } gdds_sts_t;

    // leap year from the two low year bits and the year mod 400
    function automatic logic is_leap(input logic [1:0] y_lo, input logic [R_W-1:0] r400);
        logic cent;
        cent = (r400 == R_W'(100)) || (r400 == R_W'(200)) || (r400 == R_W'(300));
        return (y_lo == 2'b00) && !cent;
    endfunction

    // days in a month, zero for a month outside 1 to 12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
            4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
            default:                                    len = '0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[sv/gregorian_date_day_stepper.sv]
// gregorian_date_day_stepper: top level, stream ports around controller and datapath
// depends on gdds_pkg, gdds_ctrl and gdds_datapath
`default_nettype none

// Takes a Gregorian date, a direction and a day count, and moves the date that many
// days forward or backward, one day per clock through a single stepping datapath.
// After acceptance a request passes through the year mod 400 computation (quotient,
// then remainder), the date check, the per-day step loop over N days, N being the
// number of days actually stepped (zero for an invalid date, at most 4095), the check
// that finds the count spent or the year limit reached, and the result load. A sink
// that holds off keeps the result load waiting. One request is worked at a time; a
// new one is taken on the cycle after the previous result is loaded into the output
// register, even if the sink has not yet taken it. An invalid date (day 0, month
// outside 1 to 12, day past month end, year past 9999) comes back unchanged with
// date_valid low. Stepping past 31/12/9999 or before 1/1/0 stops at that date and
// raises range_error.
module gregorian_date_day_stepper (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [gdds_pkg::S_TDATA_W-1:0]  s_tdata,  // day, month, year, day_count
    input  wire logic                            s_tuser,  // req_type
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [gdds_pkg::M_TDATA_W-1:0]       m_tdata,  // out_day, out_month, out_year
    output logic [gdds_pkg::M_TUSER_W-1:0]       m_tuser   // date_valid, range_error
);

    localparam int MON_LO  = gdds_pkg::DAY_W;
    localparam int YEAR_LO = MON_LO + gdds_pkg::MONTH_W;
    localparam int CNT_LO  = YEAR_LO + gdds_pkg::YEAR_W;
    localparam int USED_W  = CNT_LO + gdds_pkg::DAY_COUNT_W;
    localparam int OUT_W   = YEAR_LO + gdds_pkg::YEAR_W;

    gdds_pkg::gdds_cmd_t cmd;
    gdds_pkg::gdds_sts_t sts;

    logic [gdds_pkg::DAY_W-1:0]   o_day;
    logic [gdds_pkg::MONTH_W-1:0] o_month;
    logic [gdds_pkg::YEAR_W-1:0]  o_year;
    logic                         o_date_valid;
    logic                         o_range_error;
    logic [gdds_pkg::S_TDATA_W-USED_W-1:0] pad_unused;

    // padding bits of the input transaction carry nothing
    assign pad_unused = s_tdata[gdds_pkg::S_TDATA_W-1:USED_W];

    // sequencer
    gdds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // date registers and stepper
    gdds_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_dir          (s_tuser),
        .in_day          (s_tdata[MON_LO-1:0]),
        .in_month        (s_tdata[YEAR_LO-1:MON_LO]),
        .in_year         (s_tdata[CNT_LO-1:YEAR_LO]),
        .in_count        (s_tdata[USED_W-1:CNT_LO]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_day         (o_day),
        .out_month       (o_month),
        .out_year        (o_year),
        .out_date_valid  (o_date_valid),
        .out_range_error (o_range_error)
    );

    // result packing
    assign m_tdata = {(gdds_pkg::M_TDATA_W-OUT_W)'(pad_unused & '0), o_year, o_month, o_day};
    assign m_tuser = {o_range_error, o_date_valid};

`ifndef SYNTHESIS
    // a taken request blocks input until the result is registered
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accepting a request");

    // range error only on a valid starting date
    a_err_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(o_range_error && !o_date_valid))
        else $error("range_error set on an invalid date");

    // range error leaves the date at one of the two limits
    a_err_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && o_range_error |->
            (o_year == gdds_pkg::YEAR_MAX && o_month == gdds_pkg::MONTH_DEC
                && o_day == gdds_pkg::DAY_LAST)
            || (o_year == '0 && o_month == gdds_pkg::MONTH_JAN
                && o_day == gdds_pkg::DAY_FIRST))
        else $error("range_error with a date away from the year limits");

    // a valid result never has day zero
    a_valid_day: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && o_date_valid |-> o_day != '0)
        else $error("valid result with day zero");
`endif

endmodule

`default_nettype wire

[sv/gdds_ctrl.sv]
// gdds_ctrl: state machine sequencing one request through the datapath
// depends on gdds_pkg for command and status structs
`default_nettype none

module gdds_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire gdds_pkg::gdds_sts_t sts,
    output gdds_pkg::gdds_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_STEP  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.calc_q = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.calc_r = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (sts.done)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.at_limit)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[sv/gdds_datapath.sv]
// gdds_datapath: date registers, year mod 400 unit, day stepper and result register
// depends on gdds_pkg for widths, constants and calendar functions
`default_nettype none

module gdds_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gdds_pkg::gdds_cmd_t           cmd,
    output gdds_pkg::gdds_sts_t                sts,
    input  wire logic                          in_dir,
    input  wire logic [gdds_pkg::DAY_W-1:0]    in_day,
    input  wire logic [gdds_pkg::MONTH_W-1:0]  in_month,
    input  wire logic [gdds_pkg::YEAR_W-1:0]   in_year,
    input  wire logic [gdds_pkg::DAY_COUNT_W-1:0] in_count,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gdds_pkg::DAY_W-1:0]         out_day,
    output logic [gdds_pkg::MONTH_W-1:0]       out_month,
    output logic [gdds_pkg::YEAR_W-1:0]        out_year,
    output logic                               out_date_valid,
    output logic                               out_range_error
);

    localparam int PROD_W = gdds_pkg::YEAR_W + gdds_pkg::Q_W;
    localparam int DIFF_W = gdds_pkg::YEAR_W + 1;

    // working date
    logic                            dir_reg;
    logic [gdds_pkg::DAY_W-1:0]      day_reg,   day_next;
    logic [gdds_pkg::MONTH_W-1:0]    mon_reg,   mon_next;
    logic [gdds_pkg::YEAR_W-1:0]     year_reg,  year_next;
    logic [gdds_pkg::R_W-1:0]        r400_reg,  r400_next;
    logic [gdds_pkg::CNT_W-1:0]      cnt_reg;
    logic [gdds_pkg::Q_W-1:0]        q_reg;
    logic                            valid_reg;
    logic                            err_reg;

    // result register
    logic                            m_valid_reg;
    logic [gdds_pkg::DAY_W-1:0]      o_day_reg;
    logic [gdds_pkg::MONTH_W-1:0]    o_mon_reg;
    logic [gdds_pkg::YEAR_W-1:0]     o_year_reg;
    logic                            o_valid_reg;
    logic                            o_err_reg;

    logic [PROD_W-1:0]               prod;
    logic [DIFF_W-1:0]               diff;
    logic [gdds_pkg::R_W:0]          rem;
    logic [gdds_pkg::R_W-1:0]        rem_fix;
    logic                            leap;
    logic [gdds_pkg::DAY_W-1:0]      mlen;
    logic [gdds_pkg::DAY_W-1:0]      prev_len;
    logic                            date_ok;
    logic                            lim_fwd;
    logic                            lim_bwd;

    // quotient estimate of year / 400
    assign prod = PROD_W'(year_reg) * PROD_W'(gdds_pkg::QUOT_MUL);

    // remainder with one correction
    assign diff    = DIFF_W'(year_reg) - DIFF_W'(q_reg) * DIFF_W'(gdds_pkg::LEAP_CYCLE);
    assign rem     = diff[gdds_pkg::R_W:0];
    assign rem_fix = (rem >= (gdds_pkg::R_W+1)'(gdds_pkg::LEAP_CYCLE))
                   ? gdds_pkg::R_W'(rem - (gdds_pkg::R_W+1)'(gdds_pkg::LEAP_CYCLE))
                   : gdds_pkg::R_W'(rem);

    // month lengths of the working date
    assign leap     = gdds_pkg::is_leap(year_reg[1:0], r400_reg);
    assign mlen     = gdds_pkg::month_len(mon_reg, leap);
    assign prev_len = gdds_pkg::month_len(mon_reg - gdds_pkg::MONTH_W'(1), leap);

    // starting date check
    assign date_ok = (year_reg <= gdds_pkg::YEAR_MAX) && (day_reg != '0) && (day_reg <= mlen);

    // stepping would leave the year range
    assign lim_fwd = (day_reg >= mlen) && (mon_reg >= gdds_pkg::MONTH_DEC)
                   && (year_reg >= gdds_pkg::YEAR_MAX);
    assign lim_bwd = (day_reg <= gdds_pkg::DAY_FIRST) && (mon_reg <= gdds_pkg::MONTH_JAN)
                   && (year_reg == '0);

    assign sts.done     = !valid_reg || (cnt_reg == '0);
    assign sts.at_limit = (dir_reg == gdds_pkg::DIR_FWD) ? lim_fwd : lim_bwd;
    assign sts.out_free = !m_valid_reg || out_ready;

    // one day forward or backward
    always_comb
    begin
        day_next  = day_reg;
        mon_next  = mon_reg;
        year_next = year_reg;
        r400_next = r400_reg;
        if (dir_reg == gdds_pkg::DIR_FWD)
        begin
            if (day_reg < mlen)
            begin
                day_next = day_reg + gdds_pkg::DAY_W'(1);
            end
            else if (mon_reg < gdds_pkg::MONTH_DEC)
            begin
                day_next = gdds_pkg::DAY_FIRST;
                mon_next = mon_reg + gdds_pkg::MONTH_W'(1);
            end
            else
            begin
                day_next  = gdds_pkg::DAY_FIRST;
                mon_next  = gdds_pkg::MONTH_JAN;
                year_next = year_reg + gdds_pkg::YEAR_W'(1);
                r400_next = (r400_reg == gdds_pkg::R_W'(gdds_pkg::LEAP_CYCLE - 1))
                          ? '0 : r400_reg + gdds_pkg::R_W'(1);
            end
        end
        else
        begin
            if (day_reg > gdds_pkg::DAY_FIRST)
            begin
                day_next = day_reg - gdds_pkg::DAY_W'(1);
            end
            else if (mon_reg > gdds_pkg::MONTH_JAN)
            begin
                mon_next = mon_reg - gdds_pkg::MONTH_W'(1);
                day_next = prev_len;
            end
            else
            begin
                year_next = year_reg - gdds_pkg::YEAR_W'(1);
                mon_next  = gdds_pkg::MONTH_DEC;
                day_next  = gdds_pkg::DAY_LAST;
                r400_next = (r400_reg == '0)
                          ? gdds_pkg::R_W'(gdds_pkg::LEAP_CYCLE - 1)
                          : r400_reg - gdds_pkg::R_W'(1);
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            dir_reg  <= in_dir;
            day_reg  <= in_day;
            mon_reg  <= in_month;
            year_reg <= in_year;
            cnt_reg  <= in_count[gdds_pkg::CNT_W-1:0];
            err_reg  <= 1'b0;
        end
        if (cmd.calc_q)
        begin
            q_reg <= prod[gdds_pkg::DIV_SHIFT +: gdds_pkg::Q_W];
        end
        if (cmd.calc_r)
        begin
            r400_reg <= rem_fix;
        end
        if (cmd.check)
        begin
            valid_reg <= date_ok;
        end
        if (cmd.step)
        begin
            day_reg  <= day_next;
            mon_reg  <= mon_next;
            year_reg <= year_next;
            r400_reg <= r400_next;
            cnt_reg  <= cnt_reg - gdds_pkg::CNT_W'(1);
        end
        if (cmd.set_err)
        begin
            err_reg <= 1'b1;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            o_day_reg   <= day_reg;
            o_mon_reg   <= mon_reg;
            o_year_reg  <= year_reg;
            o_valid_reg <= valid_reg;
            o_err_reg   <= err_reg;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = m_valid_reg;
    assign out_day         = o_day_reg;
    assign out_month       = o_mon_reg;
    assign out_year        = o_year_reg;
    assign out_date_valid  = o_valid_reg;
    assign out_range_error = o_err_reg;

endmodule

`default_nettype wire
